// ----- sv/hfb_pkg.sv -----
// Package for the host frame builder: shared constants, the work descriptor
// that travels from front to back, and the byte sequencer step codes.
// No dependencies.
`default_nettype none
package hfb_pkg;

  localparam logic [7:0] TFI_HOST   = 8'hD4;
  localparam logic [7:0] ADDR_RESET = 8'h48;
  localparam logic [7:0] PREAMBLE   = 8'h00;
  localparam logic [7:0] START_LO   = 8'h00;
  localparam logic [7:0] START_HI   = 8'hFF;
  localparam logic [7:0] POSTAMBLE  = 8'h00;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // One unit of work: which runs to emit and the bytes they need.
  typedef struct packed {
    logic       hdr;
    logic       dat;
    logic       tail;
    logic [7:0] data;
    logic [7:0] flen;
    logic [7:0] dcs;
  } desc_t;

  typedef enum logic [9:0] {
    ST_ADDR   = 10'b00_0000_0001,
    ST_PRE    = 10'b00_0000_0010,
    ST_START0 = 10'b00_0000_0100,
    ST_START1 = 10'b00_0000_1000,
    ST_LEN    = 10'b00_0001_0000,
    ST_LCS    = 10'b00_0010_0000,
    ST_TFI    = 10'b00_0100_0000,
    ST_DATA   = 10'b00_1000_0000,
    ST_DCS    = 10'b01_0000_0000,
    ST_POST   = 10'b10_0000_0000
  } step_t;

endpackage
`default_nettype wire

// ----- sv/nfc_host_frame_builder.sv -----
// Top level of the host command frame builder: configuration register,
// front end, descriptor queue and byte sequencer. Depends on hfb_pkg,
// hfb_front, hfb_fifo and hfb_back.
//
//  channel | handshake       | payload
//  --------+-----------------+---------------------------------------------
//  input   | push / full     | data_byte, frame_len, start_of_frame,
//          |                 | end_of_frame, empty_payload
//  result  | empty / pop     | out_byte, last_of_run, frame_done
//  config  | cfg_write       | cfg_data (bus write address)
//
// Each accepted item is classified in its accept cycle and, unless it emits
// nothing, queued as one descriptor; the sequencer then emits one byte per
// cycle while pop is high, so an item makes 1 result mid-frame, 9 on an
// empty frame and up to 10 when one item opens and closes a frame with a
// data byte. The first result of an item on an idle block shows once its
// descriptor has passed through the queue registers into the sequencer.
// Reset is synchronous; the address register returns to 0x48 and the sum
// to 0xD4. A stall on the result side fills the four-entry queue before
// full rises; input stalls never disturb results already queued.
`default_nettype none
module nfc_host_frame_builder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte,
  input  wire logic [7:0] frame_len,
  input  wire logic       start_of_frame,
  input  wire logic       end_of_frame,
  input  wire logic       empty_payload,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            last_of_run,
  output logic            frame_done,
  input  wire logic       cfg_write,
  input  wire logic [7:0] cfg_data
);
  import hfb_pkg::*;

  logic [7:0] bus_write_address;
  desc_t      front_desc;
  desc_t      head;
  logic       desc_push;
  logic       head_valid;
  logic       head_take;
  logic       accept;

  // Hold the bus write address until software rewrites it.
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_write_address <= ADDR_RESET;
    end else if (cfg_write) begin
      bus_write_address <= cfg_data;
    end
  end

  assign accept = push && !full;

  hfb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (data_byte),
    .frame_len      (frame_len),
    .start_of_frame (start_of_frame),
    .end_of_frame   (end_of_frame),
    .empty_payload  (empty_payload),
    .desc           (front_desc),
    .desc_push      (desc_push)
  );

  // Queue full doubles as input backpressure, so items that emit nothing
  // also wait; that keeps accept independent of the item's fields.
  hfb_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (desc_push),
    .wdata    (front_desc),
    .rd       (head_take),
    .rdata    (head),
    .full     (full),
    .nonempty (head_valid)
  );

  hfb_back u_back (
    .clk               (clk),
    .rst               (rst),
    .bus_write_address (bus_write_address),
    .head              (head),
    .head_valid        (head_valid),
    .head_take         (head_take),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .last_of_run       (last_of_run),
    .frame_done        (frame_done)
  );

  // The postamble always closes the run of its item.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_done) |-> last_of_run)
    else $error("postamble shown without last_of_run");

  // Bytes of one run follow without a gap.
  a_run_unbroken: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_of_run) |=> !empty)
    else $error("result stream broke inside a run");

  // A full queue means the sequencer already holds work.
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("queue full while sequencer idle");

endmodule
`default_nettype wire

// ----- sv/hfb_front.sv -----
// Front end: accepts input items, tracks the open frame and the data sum,
// and turns each item that emits bytes into a work descriptor. Depends on hfb_pkg.
`default_nettype none
module hfb_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  input  wire logic [7:0]    frame_len,
  input  wire logic          start_of_frame,
  input  wire logic          end_of_frame,
  input  wire logic          empty_payload,
  output hfb_pkg::desc_t     desc,
  output logic               desc_push
);
  import hfb_pkg::*;

  logic [7:0] sum;
  logic       in_frame;
  logic [7:0] sum_next;
  logic       active;

  always_comb begin
    active   = start_of_frame || in_frame;
    sum_next = (start_of_frame ? TFI_HOST : sum) + (empty_payload ? 8'h00 : data_byte);
    desc.hdr  = start_of_frame;
    desc.dat  = active && !empty_payload;
    desc.tail = active && end_of_frame;
    desc.data = data_byte;
    desc.flen = frame_len;
    desc.dcs  = 8'h00 - sum_next;
    desc_push = accept && (desc.hdr || desc.dat || desc.tail);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= TFI_HOST;
      in_frame <= 1'b0;
    end else if (accept && active) begin
      // Reseed on close, carry the sum otherwise.
      if (end_of_frame) begin
        sum      <= TFI_HOST;
        in_frame <= 1'b0;
      end else begin
        sum      <= sum_next;
        in_frame <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/hfb_fifo.sv -----
// Short descriptor queue between front and back, in flip-flops.
// Depends on hfb_pkg.
`default_nettype none
module hfb_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire hfb_pkg::desc_t wdata,
  input  wire logic           rd,
  output hfb_pkg::desc_t      rdata,
  output logic                full,
  output logic                nonempty
);
  import hfb_pkg::*;

  desc_t             slots [QDEPTH];
  logic [QAW-1:0]    wptr;
  logic [QAW-1:0]    rptr;
  logic [QAW:0]      count;

  assign full     = (count == (QAW+1)'(QDEPTH));
  assign nonempty = (count != '0);
  assign rdata    = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) slots[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/hfb_back.sv -----
// Back end: takes descriptors from the queue and steps through the bytes
// they call for, one result per cycle while pop is high. Depends on hfb_pkg.
`default_nettype none
module hfb_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    bus_write_address,
  input  wire hfb_pkg::desc_t head,
  input  wire logic          head_valid,
  output logic               head_take,
  output logic               empty,
  input  wire logic          pop,
  output logic [7:0]         out_byte,
  output logic               last_of_run,
  output logic               frame_done
);
  import hfb_pkg::*;

  desc_t cur;
  step_t step;
  step_t step_next;
  step_t first_step;
  logic  busy;
  logic  load;

  always_comb begin
    out_byte    = 8'h00;
    last_of_run = 1'b0;
    frame_done  = 1'b0;
    step_next   = ST_POST;
    unique case (step)
      ST_ADDR:   begin out_byte = bus_write_address; step_next = ST_PRE; end
      ST_PRE:    begin out_byte = PREAMBLE;          step_next = ST_START0; end
      ST_START0: begin out_byte = START_LO;          step_next = ST_START1; end
      ST_START1: begin out_byte = START_HI;          step_next = ST_LEN; end
      ST_LEN:    begin out_byte = cur.flen;          step_next = ST_LCS; end
      ST_LCS:    begin out_byte = 8'h00 - cur.flen;  step_next = ST_TFI; end
      ST_TFI: begin
        out_byte    = TFI_HOST;
        step_next   = cur.dat ? ST_DATA : ST_DCS;
        last_of_run = !cur.dat && !cur.tail;
      end
      ST_DATA: begin
        out_byte    = cur.data;
        step_next   = ST_DCS;
        last_of_run = !cur.tail;
      end
      ST_DCS:    begin out_byte = cur.dcs; step_next = ST_POST; end
      ST_POST: begin
        out_byte    = POSTAMBLE;
        last_of_run = 1'b1;
        frame_done  = 1'b1;
      end
      default: begin
        out_byte = 8'h00;
      end
    endcase
  end

  always_comb begin
    if (head.hdr)      first_step = ST_ADDR;
    else if (head.dat) first_step = ST_DATA;
    else               first_step = ST_DCS;
  end

  assign empty     = !busy;
  // Refill when idle or when the last byte of a run leaves.
  assign load      = !busy || (pop && last_of_run);
  assign head_take = load && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ST_ADDR;
    end else if (load) begin
      busy <= head_valid;
      if (head_valid) step <= first_step;
    end else if (pop) begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (head_take) cur <= head;
  end

endmodule
`default_nettype wire
